/* sv/variable_record_overwrite_ring_log_unit_assert.svh */
// Assertion macros for the record ring log unit.
// Included by modules that carry concurrent checks; needs clk and rst in scope.
`ifndef VARIABLE_RECORD_OVERWRITE_RING_LOG_UNIT_ASSERT_SVH
`define VARIABLE_RECORD_OVERWRITE_RING_LOG_UNIT_ASSERT_SVH

// condition must hold at every edge out of reset
`define VROL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define VROL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define VROL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/vrol_pkg.sv */
// Shared types and codes for the record ring log unit.
// No dependencies.
package vrol_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_GRANT  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LOG  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_STRAY    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_SZ,
    S_RD
  } state_t;

endpackage

/* sv/vrol_ring_mem.sv */
// Byte store for all log rings: one write port, one registered read port.
// No dependencies.
module vrol_ring_mem #(
  parameter int ADDR_W = 13,
  parameter int DEPTH  = 8192
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/variable_record_overwrite_ring_log_unit.sv */
// Top level of the record ring log unit: per-log offsets and the control sequencer.
// Depends on vrol_pkg, vrol_ring_mem and the assertion macro header.
//
// One item is taken when start is high and busy is low; every item gives exactly one
// result, shown for one cycle with strobe high, which the receiver must take. A record
// byte, a rejected item, a record start that fits and a read request on an empty log
// give their result in the cycle after acceptance; a read byte's result is registered
// in S_RD. A record start that overflows the ring and a read request walk the stored
// record headers through the single read port of the byte store, in S_LO, S_HI and
// S_SZ for each record visited: those skipped, or those granted and any that ended the
// grant. There is no clearing pass after reset.
`include "variable_record_overwrite_ring_log_unit_assert.svh"

module variable_record_overwrite_ring_log_unit #(
  parameter int RING_BYTES   = 4096,
  parameter int HEADER_BYTES = 12,
  parameter int LOG_COUNT    = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  log_select,
  input  logic [15:0] payload_len,
  input  logic [7:0]  data_byte,
  input  logic [15:0] read_budget,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [12:0] granted_bytes,
  output logic [7:0]  read_data,
  output logic        grant_done
);
  import vrol_pkg::*;

  localparam int AW  = $clog2(RING_BYTES);
  localparam int OW  = AW + 2;
  localparam int FW  = AW + 1;
  localparam int LW  = (LOG_COUNT > 1) ? $clog2(LOG_COUNT) : 1;
  localparam int ACW = ((OW > 17) ? OW : 17) + 1;
  localparam int MAW = LW + AW;

  state_t state, state_next;

  logic [OW-1:0] wo [LOG_COUNT];
  logic [OW-1:0] ro [LOG_COUNT];
  logic [FW-1:0] fill [LOG_COUNT];
  logic [FW-1:0] grant [LOG_COUNT];

  logic [1:0]     op_q;
  logic [LW-1:0]  lg_q;
  logic [15:0]    budget_q;
  logic [OW-1:0]  need_q;
  logic [OW-1:0]  diff_q;
  logic [ACW-1:0] acc;
  logic [7:0]     lo_q;

  logic           accept, known, too_long, ovf;
  logic [LW-1:0]  lgi;
  logic [ACW-1:0] total;
  logic [OW-1:0]  wo_new, diff_new, avail_in, pos, base, base_rd, gclamp;
  logic [ACW-1:0] size, acc_sz;
  logic           stop;

  logic           mem_we, mem_re;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign lgi    = log_select[LW-1:0];
  assign known  = ({1'b0, log_select} < 3'(LOG_COUNT));
  assign total  = ACW'(HEADER_BYTES) + ACW'(payload_len);
  assign too_long = total > ACW'(RING_BYTES);
  assign wo_new   = wo[lgi] + OW'(total);
  assign diff_new = wo_new - ro[lgi];
  assign ovf      = diff_new > OW'(RING_BYTES);
  assign avail_in = wo[lgi] - ro[lgi];
  assign pos      = wo[lgi] - OW'(fill[lgi]);
  assign base     = ro[lg_q] + OW'(acc);
  assign base_rd  = base + OW'(1);
  assign size     = ACW'(HEADER_BYTES) + ACW'({mem_rdata, lo_q});
  assign acc_sz   = acc + size;
  assign gclamp   = (acc_sz > ACW'(diff_q)) ? diff_q : acc_sz[OW-1:0];
  assign stop     = (size > (ACW'(diff_q) - acc)) || (acc_sz > ACW'(budget_q));

  always_comb begin
    state_next = state;
    mem_we    = 1'b0;
    mem_waddr = {lgi, pos[AW-1:0]};
    mem_re    = 1'b0;
    mem_raddr = {lg_q, base[AW-1:0]};
    unique case (state)
      S_IDLE: begin
        if (accept && known) begin
          unique case (opcode)
            OP_START: if (!too_long && ovf) state_next = S_LO;
            OP_BYTE:  mem_we = (fill[lgi] != '0);
            OP_GRANT: if (avail_in != '0) state_next = S_LO;
            OP_READ: begin
              if (grant[lgi] != '0) begin
                mem_re     = 1'b1;
                mem_raddr  = {lgi, ro[lgi][AW-1:0]};
                state_next = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LO: begin
        mem_re     = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        mem_re     = 1'b1;
        mem_raddr  = {lg_q, base_rd[AW-1:0]};
        state_next = S_SZ;
      end
      S_SZ: begin
        if (op_q == OP_START) begin
          state_next = (acc_sz < ACW'(need_q)) ? S_LO : S_IDLE;
        end else begin
          state_next = (stop || (acc_sz >= ACW'(diff_q))) ? S_IDLE : S_LO;
        end
      end
      S_RD:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      for (int i = 0; i < LOG_COUNT; i++) begin
        wo[i]    <= '0;
        ro[i]    <= '0;
        fill[i]  <= '0;
        grant[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q          <= opcode;
            lg_q          <= lgi;
            budget_q      <= read_budget;
            acc           <= '0;
            status        <= ST_OK;
            granted_bytes <= '0;
            read_data     <= '0;
            grant_done    <= 1'b0;
            if (!known) begin
              status <= ST_BAD_LOG;
              strobe <= 1'b1;
            end else begin
              unique case (opcode)
                OP_START: begin
                  if (too_long) begin
                    status <= ST_TOO_LONG;
                    strobe <= 1'b1;
                  end else begin
                    wo[lgi]   <= wo_new;
                    fill[lgi] <= FW'(total);
                    diff_q    <= diff_new;
                    need_q    <= diff_new - OW'(RING_BYTES);
                    strobe    <= !ovf;
                  end
                end
                OP_BYTE: begin
                  strobe <= 1'b1;
                  if (fill[lgi] == '0) status <= ST_STRAY;
                  else fill[lgi] <= fill[lgi] - FW'(1);
                end
                OP_GRANT: begin
                  diff_q <= avail_in;
                  if (avail_in == '0) begin
                    grant[lgi] <= '0;
                    status     <= ST_EMPTY;
                    strobe     <= 1'b1;
                  end
                end
                OP_READ: begin
                  if (grant[lgi] == '0) begin
                    status <= ST_STRAY;
                    strobe <= 1'b1;
                  end else begin
                    ro[lgi]    <= ro[lgi] + OW'(1);
                    grant[lgi] <= grant[lgi] - FW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_LO: ;
        S_HI: lo_q <= mem_rdata;
        S_SZ: begin
          if (op_q == OP_START) begin
            if (acc_sz < ACW'(need_q)) begin
              acc <= acc_sz;
            end else begin
              ro[lg_q]    <= ro[lg_q] + gclamp;
              grant[lg_q] <= '0;
              strobe      <= 1'b1;
            end
          end else if (stop) begin
            grant[lg_q]   <= FW'(acc);
            granted_bytes <= acc[12:0];
            status        <= (acc == '0) ? ST_EMPTY : ST_OK;
            strobe        <= 1'b1;
          end else if (acc_sz >= ACW'(diff_q)) begin
            grant[lg_q]   <= FW'(acc_sz);
            granted_bytes <= acc_sz[12:0];
            strobe        <= 1'b1;
          end else begin
            acc <= acc_sz;
          end
        end
        S_RD: begin
          read_data  <= mem_rdata;
          grant_done <= (grant[lg_q] == '0);
          strobe     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  vrol_ring_mem #(
    .ADDR_W(MAW),
    .DEPTH (LOG_COUNT * RING_BYTES)
  ) u_mem (
    .clk  (clk),
    .wr_en(mem_we),
    .waddr(mem_waddr),
    .wdata(data_byte),
    .rd_en(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  `VROL_ASSERT_NEXT(a_accept_busy, accept && known && (opcode == OP_READ) && (grant[lgi] != '0), busy)
  `VROL_ASSERT_IMPLIES(a_strobe_idle, strobe, !busy)
  `VROL_ASSERT_IMPLIES(a_done_ok, strobe && grant_done, status == ST_OK)
  `VROL_ASSERT_IMPLIES(a_ring_bound, !busy, OW'(wo[0] - ro[0]) <= OW'(RING_BYTES))

endmodule

/* tb/variable_record_overwrite_ring_log_unit_tb.sv */
// Testbench for the record ring log unit: directed and random record, read and drain traffic.
// Depends on vrol_pkg and variable_record_overwrite_ring_log_unit; checks every result in order.
module variable_record_overwrite_ring_log_unit_tb;
  import vrol_pkg::*;

  localparam int RING = 4096;
  localparam int HDR = 12;
  localparam int LOGS = 2;
  localparam int RAW = $clog2(RING);

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] granted_bytes;
    logic [7:0]  read_data;
    logic        grant_done;
  } log_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_START;
  logic [1:0]  log_select = '0;
  logic [15:0] payload_len = '0;
  logic [7:0]  data_byte = '0;
  logic [15:0] read_budget = '0;
  logic        strobe;
  logic [2:0]  status;
  logic [12:0] granted_bytes;
  logic [7:0]  read_data;
  logic        grant_done;

  logic [7:0]  ring_bytes [LOGS][RING];
  logic [31:0] wr_off [LOGS];
  logic [31:0] rd_off [LOGS];
  logic [31:0] fill_left [LOGS];
  logic [31:0] grant_left [LOGS];

  log_result_t pending_results [$];
  int          mismatches = 0;
  int          sent = 0;

  variable_record_overwrite_ring_log_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .log_select(log_select), .payload_len(payload_len),
    .data_byte(data_byte), .read_budget(read_budget), .strobe(strobe),
    .status(status), .granted_bytes(granted_bytes), .read_data(read_data),
    .grant_done(grant_done)
  );

  always #5 clk = ~clk;

  initial begin
    #1_000_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [RAW-1:0] ring_idx(logic [31:0] off);
    return off[RAW-1:0];
  endfunction

  function automatic logic [31:0] stored_size(int lg, logic [31:0] off);
    return HDR + {ring_bytes[lg][ring_idx(off + 1)], ring_bytes[lg][ring_idx(off)]};
  endfunction

  function automatic log_result_t log_predict(logic [1:0] op, logic [1:0] lsel,
                                              logic [15:0] plen, logic [7:0] db,
                                              logic [15:0] bud);
    log_result_t r;
    int lg;
    logic [31:0] total, diff, need, gone, avail, cnt, sz, pos;
    r = '0;
    lg = lsel;
    if (lsel >= LOGS) begin
      r.status = ST_BAD_LOG;
    end else if (op == OP_START) begin
      total = HDR + plen;
      if (total > RING) begin
        r.status = ST_TOO_LONG;
      end else begin
        wr_off[lg] += total;
        fill_left[lg] = total;
        diff = wr_off[lg] - rd_off[lg];
        if (diff > RING) begin
          need = diff - RING;
          gone = 0;
          while (gone < need) gone += stored_size(lg, rd_off[lg] + gone);
          if (gone > diff) gone = diff;
          rd_off[lg] += gone;
          grant_left[lg] = 0;
        end
      end
    end else if (op == OP_BYTE) begin
      if (fill_left[lg] == 0) begin
        r.status = ST_STRAY;
      end else begin
        pos = wr_off[lg] - fill_left[lg];
        ring_bytes[lg][ring_idx(pos)] = db;
        fill_left[lg]--;
      end
    end else if (op == OP_GRANT) begin
      avail = wr_off[lg] - rd_off[lg];
      cnt = 0;
      while (cnt < avail) begin
        sz = stored_size(lg, rd_off[lg] + cnt);
        if (sz > avail - cnt || cnt + sz > bud) break;
        cnt += sz;
      end
      grant_left[lg] = cnt;
      r.granted_bytes = cnt[12:0];
      if (cnt == 0) r.status = ST_EMPTY;
    end else begin
      if (grant_left[lg] == 0) begin
        r.status = ST_STRAY;
      end else begin
        r.read_data = ring_bytes[lg][ring_idx(rd_off[lg])];
        rd_off[lg]++;
        grant_left[lg]--;
        r.grant_done = (grant_left[lg] == 0);
      end
    end
    return r;
  endfunction

  function automatic int idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] op, logic [1:0] lsel, logic [15:0] plen,
                           logic [7:0] db, logic [15:0] bud);
    int gap;
    start <= 1'b1;
    opcode <= op;
    log_select <= lsel;
    payload_len <= plen;
    data_byte <= db;
    read_budget <= bud;
    do @(posedge clk); while (busy);
    pending_results.push_back(log_predict(op, lsel, plen, db, bud));
    sent++;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    log_result_t want;
    log_result_t got;
    if (!rst && strobe) begin
      got = '{status, granted_bytes, read_data, grant_done};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: got %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: st %0d/%0d gr %0d/%0d rd %h/%h dn %b/%b",
                     want.status, got.status, want.granted_bytes, got.granted_bytes,
                     want.read_data, got.read_data, want.grant_done, got.grant_done);
        end
      end
    end
  end

  // record with a well-formed header unless bad_hdr is set; fill_cnt < 0 fills it completely
  task automatic put_record(int lg, int plen, int fill_cnt, bit bad_hdr);
    int total;
    logic [7:0] b;
    total = HDR + plen;
    send_item(OP_START, 2'(lg), 16'(plen), 8'($urandom), 16'($urandom));
    if (fill_cnt < 0 || fill_cnt > total) fill_cnt = total;
    for (int i = 0; i < fill_cnt; i++) begin
      b = 8'($urandom);
      if (i == 0) b = bad_hdr ? 8'($urandom) : plen[7:0];
      if (i == 1) b = bad_hdr ? 8'($urandom) : plen[15:8];
      send_item(OP_BYTE, 2'(lg), 16'($urandom), b, 16'($urandom));
    end
  endtask

  task automatic grant_and_drain(int lg, int bud, int drain);
    send_item(OP_GRANT, 2'(lg), 16'($urandom), 8'($urandom), 16'(bud));
    if (drain < 0) drain = grant_left[lg];
    for (int i = 0; i < drain; i++)
      send_item(OP_READ, 2'(lg), 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // whole ring written once per log, so no later read sees an unwritten byte
  task automatic test_prefill();
    for (int lg = 0; lg < LOGS; lg++) put_record(lg, RING - HDR, -1, 0);
  endtask

  task automatic test_bad_log();
    send_item(OP_START, 2'd2, 16'd5, 8'hff, 16'hffff);
    send_item(OP_BYTE, 2'd3, 16'hffff, 8'h00, 16'h0);
    send_item(OP_GRANT, 2'd2, 16'h0, 8'h55, 16'd100);
    send_item(OP_READ, 2'd3, 16'h0, 8'haa, 16'h0);
  endtask

  task automatic test_too_long();
    send_item(OP_START, 2'd0, 16'(RING - HDR + 1), 8'h0, 16'h0);
    send_item(OP_START, 2'd1, 16'hffff, 8'hff, 16'hffff);
  endtask

  task automatic test_stray();
    send_item(OP_BYTE, 2'd0, 16'h0, 8'h12, 16'h0);
    send_item(OP_READ, 2'd1, 16'h0, 8'h0, 16'h0);
  endtask

  task automatic test_grant_drain();
    grant_and_drain(0, 0, 0);
    grant_and_drain(0, 16'hffff, 3);
    grant_and_drain(0, 16'hffff, -1);
    send_item(OP_READ, 2'd0, 16'h0, 8'h0, 16'h0);
  endtask

  task automatic test_overflow_pull();
    put_record(1, 0, -1, 0);
    put_record(1, 3, -1, 0);
    grant_and_drain(1, 16'hffff, 2);
    put_record(1, 0, 2, 0);
    send_item(OP_READ, 2'd1, 16'h0, 8'h0, 16'h0);
  endtask

  task automatic test_restart_open();
    put_record(0, 4, 5, 0);
    put_record(0, 1, -1, 0);
    grant_and_drain(0, 16'd30, 1);
    grant_and_drain(0, 16'd30, -1);
  endtask

  task automatic test_bad_header();
    put_record(1, 2, -1, 1);
    grant_and_drain(1, 16'hffff, -1);
  endtask

  task automatic test_random();
    int lg, p, plen;
    int sent_before;
    sent_before = sent;
    while (sent - sent_before < 1900) begin
      lg = $urandom_range(0, LOGS - 1);
      p = $urandom_range(0, 99);
      if (p < 45) begin
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, RING - HDR)
                                            : $urandom_range(0, 40);
        put_record(lg, plen, ($urandom_range(0, 9) == 0) ? $urandom_range(0, HDR + plen) : -1,
                   $urandom_range(0, 29) == 0);
      end else if (p < 85) begin
        grant_and_drain(lg, ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : -1);
      end else begin
        send_item(2'($urandom), 2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    for (int lg = 0; lg < LOGS; lg++) begin
      wr_off[lg] = 0;
      rd_off[lg] = 0;
      fill_left[lg] = 0;
      grant_left[lg] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_prefill();
    test_bad_log();
    test_too_long();
    test_stray();
    test_grant_drain();
    test_overflow_pull();
    test_restart_open();
    test_bad_header();
    test_random();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/vrol_pkg.sv
sv/vrol_ring_mem.sv
sv/variable_record_overwrite_ring_log_unit.sv
tb/variable_record_overwrite_ring_log_unit_tb.sv
